// ----- rtl/core/bco_pkg.sv -----
package bco_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int DIFF_BITS  = COORD_BITS + 2;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int RAD_BITS   = COORD_BITS;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SIZE_BITS-1:0]         size_t;
	typedef logic signed [EDGE_BITS-1:0]  edge_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic [MAG_BITS-1:0]          mag_t;
	typedef logic [RAD_BITS-1:0]          rad_t;
	typedef logic [SQ_BITS-1:0]           sq_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   is_circle;
		size_t  width;
		size_t  height;
		size_t  radius;
	} shape_t;

	// extent of a shape; a circle collapses to its centre
	typedef struct packed {
		edge_t x0;
		edge_t x1;
		edge_t y0;
		edge_t y1;
	} extent_t;

	typedef struct packed {
		extent_t first;
		extent_t second;
		logic    first_circle;
		logic    second_circle;
		rad_t    radius;
	} edge_stage_t;

	typedef struct packed {
		logic  box_box;
		logic  box_hit;
		diff_t dl_x;
		diff_t dr_x;
		diff_t dl_y;
		diff_t dr_y;
		rad_t  radius;
	} clamp_stage_t;

	typedef struct packed {
		logic box_box;
		logic box_hit;
		sq_t  sq_x;
		sq_t  sq_y;
		sq_t  sq_r;
	} square_stage_t;

endpackage

// ----- rtl/core/box_circle_overlap_test.sv -----
// channel | valid     | stall     | beat
// req     | req_valid | req_stall | first_*, second_* shape pair
// rsp     | rsp_valid | rsp_stall | hit
//
// One beat per cycle while rsp is not stalled; the stages are edges, clamp, square and compare.
// Each stage holds only while it is full and the stage after it is held.
// req_stall rises only when all four stages are full and rsp is stalled.
// arst_n clears the valid bits; data registers are not reset.
module box_circle_overlap_test (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  bco_pkg::coord_t       first_x,
	input  bco_pkg::coord_t       first_y,
	input  logic                  first_is_circle,
	input  bco_pkg::size_t        first_width,
	input  bco_pkg::size_t        first_height,
	input  bco_pkg::size_t        first_radius,
	input  bco_pkg::coord_t       second_x,
	input  bco_pkg::coord_t       second_y,
	input  logic                  second_is_circle,
	input  bco_pkg::size_t        second_width,
	input  bco_pkg::size_t        second_height,
	input  bco_pkg::size_t        second_radius,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  hit
);

	bco_pkg::shape_t        first;
	bco_pkg::shape_t        second;
	bco_pkg::edge_stage_t   edge_s1;
	bco_pkg::clamp_stage_t  clamp_s2;
	bco_pkg::square_stage_t sq_s3;
	logic                   hit_s4;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;
	logic                   valid_s4;
	logic                   en1;
	logic                   en2;
	logic                   en3;
	logic                   en4;

	assign first  = '{x: first_x, y: first_y, is_circle: first_is_circle,
		width: first_width, height: first_height, radius: first_radius};
	assign second = '{x: second_x, y: second_y, is_circle: second_is_circle,
		width: second_width, height: second_height, radius: second_radius};

	assign en4 = !valid_s4 || !rsp_stall;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign req_stall = !en1;
	assign rsp_valid = valid_s4;
	assign hit       = hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= req_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	bco_edges u_edges (
		.clk     (clk),
		.en      (en1),
		.first   (first),
		.second  (second),
		.edge_s1 (edge_s1)
	);

	bco_clamp u_clamp (
		.clk      (clk),
		.en       (en2),
		.edge_s1  (edge_s1),
		.clamp_s2 (clamp_s2)
	);

	bco_square u_square (
		.clk      (clk),
		.en       (en3),
		.clamp_s2 (clamp_s2),
		.sq_s3    (sq_s3)
	);

	bco_compare u_compare (
		.clk    (clk),
		.en     (en4),
		.sq_s3  (sq_s3),
		.hit_s4 (hit_s4)
	);

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> valid_s1)
		else $error("accepted beat did not enter the first stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && rsp_stall)
		else $error("input stalled with a bubble in the pipeline");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && valid_s4 && rsp_stall |=> valid_s3 && $stable(sq_s3))
		else $error("held stage lost or changed its beat");
`endif

endmodule

// ----- rtl/core/bco_edges.sv -----
module bco_edges (
	input  logic                 clk,
	input  logic                 en,
	input  bco_pkg::shape_t      first,
	input  bco_pkg::shape_t      second,
	output bco_pkg::edge_stage_t edge_s1
);

	function automatic bco_pkg::extent_t extent(input bco_pkg::shape_t s);
		bco_pkg::extent_t e;
		bco_pkg::edge_t   w;
		bco_pkg::edge_t   h;
		w    = s.is_circle ? '0 : $signed(bco_pkg::EDGE_BITS'(s.width));
		h    = s.is_circle ? '0 : $signed(bco_pkg::EDGE_BITS'(s.height));
		e.x0 = bco_pkg::EDGE_BITS'(s.x);
		e.y0 = bco_pkg::EDGE_BITS'(s.y);
		e.x1 = e.x0 + w;
		e.y1 = e.y0 + h;
		return e;
	endfunction

	bco_pkg::edge_stage_t nxt;

	always_comb begin
		nxt.first         = extent(first);
		nxt.second        = extent(second);
		nxt.first_circle  = first.is_circle;
		nxt.second_circle = second.is_circle;
		if (first.is_circle && second.is_circle) begin
			nxt.radius = bco_pkg::RAD_BITS'(first.radius) + bco_pkg::RAD_BITS'(second.radius);
		end else if (first.is_circle) begin
			nxt.radius = bco_pkg::RAD_BITS'(first.radius);
		end else begin
			nxt.radius = bco_pkg::RAD_BITS'(second.radius);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edge_s1 <= nxt;
		end
	end

endmodule

// ----- rtl/core/bco_clamp.sv -----
module bco_clamp (
	input  logic                  clk,
	input  logic                  en,
	input  bco_pkg::edge_stage_t  edge_s1,
	output bco_pkg::clamp_stage_t clamp_s2
);

	bco_pkg::extent_t      ctr;
	bco_pkg::extent_t      box;
	bco_pkg::clamp_stage_t nxt;

	always_comb begin
		// circle against the other shape; for two circles the other is a point
		if (edge_s1.first_circle) begin
			ctr = edge_s1.first;
			box = edge_s1.second;
		end else begin
			ctr = edge_s1.second;
			box = edge_s1.first;
		end
		nxt.box_box = !edge_s1.first_circle && !edge_s1.second_circle;
		nxt.box_hit = (edge_s1.first.x0 < edge_s1.second.x1) &&
			(edge_s1.first.x1 > edge_s1.second.x0) &&
			(edge_s1.first.y0 < edge_s1.second.y1) &&
			(edge_s1.first.y1 > edge_s1.second.y0);
		nxt.dl_x   = bco_pkg::DIFF_BITS'(box.x0) - bco_pkg::DIFF_BITS'(ctr.x0);
		nxt.dr_x   = bco_pkg::DIFF_BITS'(ctr.x0) - bco_pkg::DIFF_BITS'(box.x1);
		nxt.dl_y   = bco_pkg::DIFF_BITS'(box.y0) - bco_pkg::DIFF_BITS'(ctr.y0);
		nxt.dr_y   = bco_pkg::DIFF_BITS'(ctr.y0) - bco_pkg::DIFF_BITS'(box.y1);
		nxt.radius = edge_s1.radius;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s2 <= nxt;
		end
	end

endmodule

// ----- rtl/core/bco_square.sv -----
module bco_square (
	input  logic                   clk,
	input  logic                   en,
	input  bco_pkg::clamp_stage_t  clamp_s2,
	output bco_pkg::square_stage_t sq_s3
);

	// distance to the nearer edge, zero when inside the interval
	function automatic bco_pkg::mag_t gap(input bco_pkg::diff_t dl, input bco_pkg::diff_t dr);
		bco_pkg::mag_t m;
		if (!dl[bco_pkg::DIFF_BITS-1] && (dl != '0)) begin
			m = dl[bco_pkg::MAG_BITS-1:0];
		end else if (!dr[bco_pkg::DIFF_BITS-1] && (dr != '0)) begin
			m = dr[bco_pkg::MAG_BITS-1:0];
		end else begin
			m = '0;
		end
		return m;
	endfunction

	bco_pkg::mag_t mag_x;
	bco_pkg::mag_t mag_y;

	assign mag_x = gap(clamp_s2.dl_x, clamp_s2.dr_x);
	assign mag_y = gap(clamp_s2.dl_y, clamp_s2.dr_y);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.box_box <= clamp_s2.box_box;
			sq_s3.box_hit <= clamp_s2.box_hit;
			sq_s3.sq_x    <= bco_pkg::SQ_BITS'(mag_x) * bco_pkg::SQ_BITS'(mag_x);
			sq_s3.sq_y    <= bco_pkg::SQ_BITS'(mag_y) * bco_pkg::SQ_BITS'(mag_y);
			sq_s3.sq_r    <= bco_pkg::SQ_BITS'(clamp_s2.radius) *
				bco_pkg::SQ_BITS'(clamp_s2.radius);
		end
	end

endmodule

// ----- rtl/core/bco_compare.sv -----
module bco_compare (
	input  logic                   clk,
	input  logic                   en,
	input  bco_pkg::square_stage_t sq_s3,
	output logic                   hit_s4
);

	logic [bco_pkg::SUM_BITS-1:0] dist_sq;
	logic                         nxt;

	assign dist_sq = bco_pkg::SUM_BITS'(sq_s3.sq_x) + bco_pkg::SUM_BITS'(sq_s3.sq_y);
	assign nxt     = sq_s3.box_box ? sq_s3.box_hit
		: (dist_sq <= bco_pkg::SUM_BITS'(sq_s3.sq_r));

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= nxt;
		end
	end

endmodule
